[design/lsv_pkg.sv]
package lsv_pkg;

	localparam int MAX_SECTOR_BYTES_DEF = 4096;
	localparam int TYPE_TEXT_BYTES = 32;
	localparam int HEADER_BYTES = 72;
	localparam int TYPE_START = 40;
	localparam int BLOCK_SHIFT = 9;
	localparam logic [31:0] SECTOR_MAGIC = 32'h6c586e4c;
	localparam logic [31:0] CRC_SEED = 32'hffffffff;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECTOR_SIZE   = 3'd0,
		REG_DEVICE_BLOCKS = 3'd1,
		REG_WANTED_MAJOR  = 3'd2,
		REG_WANTED_MINOR  = 3'd3,
		REG_WANTED_PATCH  = 3'd4,
		REG_MATCH_MODE    = 3'd5
	} lsv_reg_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_MAGIC   = 3'd1,
		ST_TYPE_UNTERM = 3'd2,
		ST_TOO_LONG    = 3'd3,
		ST_CRC_BAD     = 3'd4,
		ST_SHORT       = 3'd5
	} lsv_status_t;

	typedef enum logic [1:0] {
		MM_EQUAL    = 2'd0,
		MM_MINOR_LT = 2'd1,
		MM_MINOR_LE = 2'd2,
		MM_ANY      = 2'd3
	} lsv_mode_t;

	typedef struct packed {
		logic [12:0] sector_size;
		logic [47:0] device_blocks;
		logic [31:0] wanted_major;
		logic [31:0] wanted_minor;
		logic [31:0] wanted_patch;
		lsv_mode_t   match_mode;
	} lsv_cfg_t;

	typedef struct packed {
		logic        short_sector;
		logic        magic_bad;
		logic        nul_missing;
		logic        len_bad;
		logic        crc_bad;
		logic        copy_index;
		logic [63:0] first_location;
		logic [63:0] second_location;
		logic [15:0] data_length;
		logic [95:0] version_words;
	} lsv_rec_t;

	typedef struct packed {
		lsv_status_t status;
		logic        valid_res;
		logic        use_this_copy;
		logic        loc1_wrong;
		logic        loc2_wrong;
		logic        version_accepted;
		logic [15:0] data_length;
		logic [31:0] version_major;
		logic [31:0] version_minor;
		logic [31:0] version_patch;
	} lsv_res_t;

	function automatic logic [31:0] lsv_nib(input logic [3:0] n);
		logic [31:0] v;
		case (n)
			4'h0: v = 32'h00000000;
			4'h1: v = 32'h1db71064;
			4'h2: v = 32'h3b6e20c8;
			4'h3: v = 32'h26d930ac;
			4'h4: v = 32'h76dc4190;
			4'h5: v = 32'h6b6b51f4;
			4'h6: v = 32'h4db26158;
			4'h7: v = 32'h5005713c;
			4'h8: v = 32'hedb88320;
			4'h9: v = 32'hf00f9344;
			4'ha: v = 32'hd6d6a3e8;
			4'hb: v = 32'hcb61b38c;
			4'hc: v = 32'h9b64c2b0;
			4'hd: v = 32'h86d3d2d4;
			4'he: v = 32'ha00ae278;
			default: v = 32'hbdbdf21c;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] lsv_crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] t;
		t = c ^ {24'd0, b};
		t = (t >> 4) ^ lsv_nib(t[3:0]);
		t = (t >> 4) ^ lsv_nib(t[3:0]);
		return t;
	endfunction

endpackage

[design/label_sector_validator_core.sv]
// Channel  Handshake              Payload
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in_valid / in_ready    data_byte, copy_index, byte_last
// out      out_valid / out_ready  status .. version_patch
//
// One byte per cycle while in_ready is high; the CRC nibble pair and field capture finish in the cycle of acceptance.
// A byte marked last pushes a record into the queue; the back pops it into the output register and raises out_valid.
// A two-entry queue parts the byte front from the verdict stage and the output register.
// in_ready drops only while the queue is full; cfg_ready is always high.
// Reset clears all sector state and the first-copy memory; config registers return to their defaults.
module label_sector_validator_core import lsv_pkg::*; #(
	parameter int MAX_SECTOR_BYTES = MAX_SECTOR_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  copy_index,
	input  logic                  byte_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic                  valid_res,
	output logic                  use_this_copy,
	output logic                  loc1_wrong,
	output logic                  loc2_wrong,
	output logic                  version_accepted,
	output logic [15:0]           data_length,
	output logic [31:0]           version_major,
	output logic [31:0]           version_minor,
	output logic [31:0]           version_patch
);

	lsv_cfg_t cfg_q;
	lsv_rec_t push_rec, pop_rec;
	lsv_res_t res;
	logic     q_full, q_push, q_pop, q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sector_size   <= 13'd512;
			cfg_q.device_blocks <= '0;
			cfg_q.wanted_major  <= '0;
			cfg_q.wanted_minor  <= '0;
			cfg_q.wanted_patch  <= '0;
			cfg_q.match_mode    <= MM_ANY;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SECTOR_SIZE:   cfg_q.sector_size   <= cfg_data[12:0];
				REG_DEVICE_BLOCKS: cfg_q.device_blocks <= cfg_data;
				REG_WANTED_MAJOR:  cfg_q.wanted_major  <= cfg_data[31:0];
				REG_WANTED_MINOR:  cfg_q.wanted_minor  <= cfg_data[31:0];
				REG_WANTED_PATCH:  cfg_q.wanted_patch  <= cfg_data[31:0];
				REG_MATCH_MODE:    cfg_q.match_mode    <= lsv_mode_t'(cfg_data[1:0]);
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	lsv_front #(
		.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sector_size(cfg_q.sector_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.copy_index (copy_index),
		.byte_last  (byte_last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (push_rec)
	);

	lsv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_rec  (pop_rec)
	);

	lsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_not_empty(q_not_empty),
		.q_rec      (pop_rec),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign status           = res.status;
	assign valid_res        = res.valid_res;
	assign use_this_copy    = res.use_this_copy;
	assign loc1_wrong       = res.loc1_wrong;
	assign loc2_wrong       = res.loc2_wrong;
	assign version_accepted = res.version_accepted;
	assign data_length      = res.data_length;
	assign version_major    = res.version_major;
	assign version_minor    = res.version_minor;
	assign version_patch    = res.version_patch;

	a_invalid_flags_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> !loc1_wrong && !loc2_wrong && !version_accepted
	) else $error("flags set on an invalid label");

	a_use_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && use_this_copy |-> valid_res
	) else $error("copy chosen without a valid label");

	a_ok_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_res == (status == ST_OK))
	) else $error("valid_res disagrees with status");

	a_queue_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_not_empty
	) else $error("input stalled with an empty queue");

endmodule

[design/lsv_front.sv]
module lsv_front import lsv_pkg::*; #(
	parameter int MAX_SECTOR_BYTES = MAX_SECTOR_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [12:0] sector_size,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        copy_index,
	input  logic        byte_last,
	input  logic        q_full,
	output logic        q_push,
	output lsv_rec_t    q_rec
);

	localparam int POS_W = $clog2(MAX_SECTOR_BYTES + 1);
	localparam int CMP_W = (POS_W > 13) ? POS_W : 13;
	localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_SECTOR_BYTES);
	localparam logic [CMP_W-1:0] HDR_LEN = CMP_W'(HEADER_BYTES);

	logic [POS_W-1:0] pos_q, pos_n, eff_len;
	logic [CMP_W-1:0] size_x;
	logic [31:0] crc_q, crc_n, magic_q, magic_n, scrc_q, scrc_n;
	logic [63:0] loc1_q, loc1_n, loc2_q, loc2_n;
	logic [15:0] ext_q, ext_n;
	logic [95:0] ver_q, ver_n;
	logic        nul_q, nul_n, in_crc, accept;
	logic [3:0]  ver_k;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign size_x   = CMP_W'(sector_size);
	assign ver_k    = 4'(pos_q - POS_W'(28));

	always_comb begin
		if (size_x < HDR_LEN) begin
			eff_len = POS_W'(HEADER_BYTES);
		end else if (size_x > MAX_LEN) begin
			eff_len = POS_W'(MAX_SECTOR_BYTES);
		end else begin
			eff_len = POS_W'(size_x);
		end
	end

	always_comb begin
		pos_n   = pos_q;
		magic_n = magic_q;
		scrc_n  = scrc_q;
		loc1_n  = loc1_q;
		loc2_n  = loc2_q;
		ext_n   = ext_q;
		ver_n   = ver_q;
		nul_n   = nul_q;
		in_crc  = 1'b0;
		if (pos_q < eff_len) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q < POS_W'(4)) begin
				magic_n[{pos_q[1:0], 3'b000} +: 8] = data_byte;
				in_crc = 1'b1;
			end else if (pos_q < POS_W'(8)) begin
				scrc_n[{pos_q[1:0], 3'b000} +: 8] = data_byte;
			end else if (pos_q < POS_W'(16)) begin
				loc1_n[{pos_q[2:0], 3'b000} +: 8] = data_byte;
				in_crc = 1'b1;
			end else if (pos_q < POS_W'(24)) begin
				loc2_n[{pos_q[2:0], 3'b000} +: 8] = data_byte;
				in_crc = 1'b1;
			end else if (pos_q < POS_W'(26)) begin
				ext_n[{pos_q[0], 3'b000} +: 8] = data_byte;
				in_crc = 1'b1;
			end else if (pos_q < POS_W'(28)) begin
				in_crc = 1'b0;
			end else if (pos_q < POS_W'(TYPE_START)) begin
				ver_n[{ver_k, 3'b000} +: 8] = data_byte;
				in_crc = 1'b1;
			end else if (pos_q < POS_W'(TYPE_START + TYPE_TEXT_BYTES)) begin
				if (!nul_q) begin
					if (data_byte == 8'd0) begin
						nul_n = 1'b1;
					end else begin
						in_crc = 1'b1;
					end
				end
			end else if (pos_q >= POS_W'(HEADER_BYTES)) begin
				in_crc = (32'(pos_q) - 32'(HEADER_BYTES)) < 32'(ext_q);
			end
		end
		crc_n = in_crc ? lsv_crc_byte(crc_q, data_byte) : crc_q;
	end

	always_comb begin
		q_push                = accept && byte_last;
		q_rec.short_sector    = pos_n < eff_len;
		q_rec.magic_bad       = magic_n != SECTOR_MAGIC;
		q_rec.nul_missing     = !nul_n;
		q_rec.len_bad         = 32'(ext_n) > (32'(eff_len) - 32'(HEADER_BYTES));
		q_rec.crc_bad         = scrc_n != crc_n;
		q_rec.copy_index      = copy_index;
		q_rec.first_location  = loc1_n;
		q_rec.second_location = loc2_n;
		q_rec.data_length     = ext_n;
		q_rec.version_words   = ver_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			crc_q   <= CRC_SEED;
			magic_q <= '0;
			scrc_q  <= '0;
			loc1_q  <= '0;
			loc2_q  <= '0;
			ext_q   <= '0;
			ver_q   <= '0;
			nul_q   <= 1'b0;
		end else if (accept) begin
			if (byte_last) begin
				pos_q   <= '0;
				crc_q   <= CRC_SEED;
				magic_q <= '0;
				scrc_q  <= '0;
				loc1_q  <= '0;
				loc2_q  <= '0;
				ext_q   <= '0;
				ver_q   <= '0;
				nul_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				crc_q   <= crc_n;
				magic_q <= magic_n;
				scrc_q  <= scrc_n;
				loc1_q  <= loc1_n;
				loc2_q  <= loc2_n;
				ext_q   <= ext_n;
				ver_q   <= ver_n;
				nul_q   <= nul_n;
			end
		end
	end

endmodule

[design/lsv_queue.sv]
module lsv_queue import lsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lsv_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output lsv_rec_t pop_rec
);

	lsv_rec_t   slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_rec   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/lsv_back.sv]
module lsv_back import lsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lsv_cfg_t cfg,
	input  logic     q_not_empty,
	input  lsv_rec_t q_rec,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output lsv_res_t res
);

	logic        out_valid_q, first_ok_q, valid, acc;
	lsv_status_t status;
	logic [63:0] exp2;
	logic [31:0] vmaj, vmin, vpat;
	lsv_res_t    res_q;

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign q_pop     = q_not_empty && (!out_valid_q || out_ready);
	assign vmaj      = q_rec.version_words[31:0];
	assign vmin      = q_rec.version_words[63:32];
	assign vpat      = q_rec.version_words[95:64];
	assign exp2      = 64'({cfg.device_blocks, BLOCK_SHIFT'(0)}) - 64'(cfg.sector_size);

	always_comb begin
		if (q_rec.short_sector) begin
			status = ST_SHORT;
		end else if (q_rec.magic_bad) begin
			status = ST_BAD_MAGIC;
		end else if (q_rec.nul_missing) begin
			status = ST_TYPE_UNTERM;
		end else if (q_rec.len_bad) begin
			status = ST_TOO_LONG;
		end else if (q_rec.crc_bad) begin
			status = ST_CRC_BAD;
		end else begin
			status = ST_OK;
		end
		valid = status == ST_OK;
		unique case (cfg.match_mode)
			MM_EQUAL:    acc = vmaj == cfg.wanted_major && vmin == cfg.wanted_minor &&
			                   vpat == cfg.wanted_patch;
			MM_MINOR_LT: acc = vmaj == cfg.wanted_major && vmin < cfg.wanted_minor;
			MM_MINOR_LE: acc = vmaj == cfg.wanted_major && vmin <= cfg.wanted_minor;
			default:     acc = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			first_ok_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (!q_rec.copy_index) begin
					first_ok_q <= valid;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.status           <= status;
			res_q.valid_res        <= valid;
			res_q.use_this_copy    <= valid && (!q_rec.copy_index || !first_ok_q);
			res_q.loc1_wrong       <= valid &&
			                          (q_rec.first_location != 64'(cfg.sector_size));
			res_q.loc2_wrong       <= valid && (q_rec.second_location != exp2);
			res_q.version_accepted <= valid && acc;
			res_q.data_length      <= q_rec.data_length;
			res_q.version_major    <= vmaj;
			res_q.version_minor    <= vmin;
			res_q.version_patch    <= vpat;
		end
	end

endmodule

[tb/label_sector_validator_core_test.sv]
`timescale 1ns / 1ps

module label_sector_validator_core_test;
	import lsv_pkg::*;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam int SEND_IDLE_PCT = 51;
	localparam int RECV_STALL_PCT = 51;
	localparam int BOTH_IDLE_PCT = 21;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int PRESSURE_PHASE = 6;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_BYTES = 75;
	localparam longint TIMEOUT_NS = 10_000_000;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum {
		LBL_GOOD, LBL_BAD_MAGIC, LBL_NO_NUL, LBL_TOO_LONG, LBL_BAD_CRC,
		LBL_SHORT, LBL_NOISE, LBL_STUB
	} label_kind_t;

	class label_verdict_board;
		logic [12:0] ss;
		logic [47:0] blocks;
		logic [31:0] want_major, want_minor, want_patch;
		lsv_mode_t mode;

		int unsigned pos;
		logic [31:0] crc, magic, stored_crc;
		logic [63:0] loc1, loc2;
		logic [15:0] xlen;
		logic [31:0] ver [3];
		bit nul_seen, first_ok;

		lsv_res_t verdicts[$];
		int checked, failures;

		function new();
			ss = 13'd512;
			blocks = '0;
			want_major = '0;
			want_minor = '0;
			want_patch = '0;
			mode = MM_ANY;
			first_ok = 0;
			checked = 0;
			failures = 0;
			restart();
		endfunction

		static function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
			logic [31:0] t;
			t = c ^ {24'd0, b};
			for (int i = 0; i < 8; i++)
				t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
			return t;
		endfunction

		function void restart();
			pos = 0;
			crc = CRC_SEED;
			magic = '0;
			stored_crc = '0;
			loc1 = '0;
			loc2 = '0;
			xlen = '0;
			ver[0] = '0;
			ver[1] = '0;
			ver[2] = '0;
			nul_seen = 0;
		endfunction

		function void set_reg(lsv_reg_t idx, logic [47:0] v);
			case (idx)
				REG_SECTOR_SIZE:   ss = v[12:0];
				REG_DEVICE_BLOCKS: blocks = v;
				REG_WANTED_MAJOR:  want_major = v[31:0];
				REG_WANTED_MINOR:  want_minor = v[31:0];
				REG_WANTED_PATCH:  want_patch = v[31:0];
				REG_MATCH_MODE:    mode = lsv_mode_t'(v[1:0]);
				default: ;
			endcase
		endfunction

		function int unsigned span();
			int unsigned s;
			s = 32'(ss);
			if (s < HEADER_BYTES) s = HEADER_BYTES;
			if (s > MAX_SECTOR_BYTES_DEF) s = MAX_SECTOR_BYTES_DEF;
			return s;
		endfunction

		function void take(int unsigned p, logic [7:0] b);
			bit fold;
			fold = 0;
			if (p < 4) begin
				magic[8*p +: 8] = b;
				fold = 1;
			end else if (p < 8) begin
				stored_crc[8*(p-4) +: 8] = b;
			end else if (p < 16) begin
				loc1[8*(p-8) +: 8] = b;
				fold = 1;
			end else if (p < 24) begin
				loc2[8*(p-16) +: 8] = b;
				fold = 1;
			end else if (p < 26) begin
				xlen[8*(p-24) +: 8] = b;
				fold = 1;
			end else if (p < 28) begin
				fold = 0;
			end else if (p < TYPE_START) begin
				ver[(p-28)/4][8*((p-28)%4) +: 8] = b;
				fold = 1;
			end else if (p < TYPE_START + TYPE_TEXT_BYTES) begin
				if (!nul_seen) begin
					if (b == 8'h00) nul_seen = 1;
					else fold = 1;
				end
			end else if (p >= HEADER_BYTES && p < HEADER_BYTES + xlen) begin
				fold = 1;
			end
			if (fold) crc = crc_fold(crc, b);
		endfunction

		function void note_byte(logic [7:0] b, logic copy, logic last);
			int unsigned len;
			lsv_res_t r;
			logic [63:0] loc2_want;
			bit ok;
			len = span();
			if (pos < len) begin
				take(pos, b);
				pos++;
			end
			if (!last) return;
			if (pos < len) r.status = ST_SHORT;
			else if (magic != SECTOR_MAGIC) r.status = ST_BAD_MAGIC;
			else if (!nul_seen) r.status = ST_TYPE_UNTERM;
			else if (int'(xlen) > int'(len) - HEADER_BYTES) r.status = ST_TOO_LONG;
			else if (stored_crc != crc) r.status = ST_CRC_BAD;
			else r.status = ST_OK;
			ok = (r.status == ST_OK);
			r.valid_res = ok;
			r.use_this_copy = ok && (!copy || !first_ok);
			r.loc1_wrong = 0;
			r.loc2_wrong = 0;
			r.version_accepted = 0;
			if (ok) begin
				loc2_want = ({16'd0, blocks} << BLOCK_SHIFT) - {51'd0, ss};
				r.loc1_wrong = (loc1 != {51'd0, ss});
				r.loc2_wrong = (loc2 != loc2_want);
				case (mode)
					MM_EQUAL:    r.version_accepted = ver[0] == want_major &&
						ver[1] == want_minor && ver[2] == want_patch;
					MM_MINOR_LT: r.version_accepted = ver[0] == want_major && ver[1] < want_minor;
					MM_MINOR_LE: r.version_accepted = ver[0] == want_major && ver[1] <= want_minor;
					default:     r.version_accepted = 1;
				endcase
			end
			r.data_length = xlen;
			r.version_major = ver[0];
			r.version_minor = ver[1];
			r.version_patch = ver[2];
			verdicts.push_back(r);
			if (!copy) first_ok = ok;
			restart();
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10) $display("%s", msg);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				report($sformatf("verdict %0d: %s expected %h got %h", checked, name, want, got));
		endfunction

		function void check_verdict(lsv_res_t got);
			lsv_res_t want;
			if (verdicts.size() == 0) begin
				report($sformatf("verdict with none pending: status %0d", got.status));
				return;
			end
			want = verdicts.pop_front();
			cmp_field("status", want.status, got.status);
			cmp_field("valid_res", want.valid_res, got.valid_res);
			cmp_field("use_this_copy", want.use_this_copy, got.use_this_copy);
			cmp_field("loc1_wrong", want.loc1_wrong, got.loc1_wrong);
			cmp_field("loc2_wrong", want.loc2_wrong, got.loc2_wrong);
			cmp_field("version_accepted", want.version_accepted, got.version_accepted);
			cmp_field("data_length", want.data_length, got.data_length);
			cmp_field("version_major", want.version_major, got.version_major);
			cmp_field("version_minor", want.version_minor, got.version_minor);
			cmp_field("version_patch", want.version_patch, got.version_patch);
			checked++;
		endfunction

		function void close();
			if (verdicts.size() != 0)
				report($sformatf("%0d verdicts never arrived", verdicts.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic copy_index = 1'b0;
	logic byte_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic valid_res;
	logic use_this_copy;
	logic loc1_wrong;
	logic loc2_wrong;
	logic version_accepted;
	logic [15:0] data_length;
	logic [31:0] version_major;
	logic [31:0] version_minor;
	logic [31:0] version_patch;

	label_verdict_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int bytes_sent = 0;

	label_sector_validator_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit gap_roll();
		return $urandom_range(99) < send_idle_pct;
	endfunction

	function automatic void put_le(ref logic [7:0] img[$], input int unsigned at,
			input int n, input logic [63:0] v);
		for (int k = 0; k < n; k++) img[at+k] = v[8*k +: 8];
	endfunction

	function automatic logic [31:0] near_word(logic [31:0] w);
		case ($urandom_range(3))
			0: return w;
			1: return w + 1;
			2: return w - 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic label_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 55) return LBL_GOOD;
		if (r < 62) return LBL_BAD_MAGIC;
		if (r < 68) return LBL_NO_NUL;
		if (r < 74) return LBL_TOO_LONG;
		if (r < 80) return LBL_BAD_CRC;
		if (r < 88) return LBL_SHORT;
		if (r < 94) return LBL_NOISE;
		return LBL_STUB;
	endfunction

	function automatic lsv_cfg_t phase_cfg(int ph);
		lsv_cfg_t c;
		c.sector_size = 13'(($urandom_range(7) == 0) ? $urandom_range(71) :
			$urandom_range(72, 120));
		c.device_blocks = 48'({$urandom, $urandom});
		c.wanted_major = ($urandom_range(1)) ? $urandom_range(3) : $urandom;
		c.wanted_minor = ($urandom_range(1)) ? $urandom_range(3) : $urandom;
		c.wanted_patch = $urandom;
		c.match_mode = lsv_mode_t'($urandom_range(3));
		case (ph)
			1: begin
				c.sector_size = 13'd72;
				c.device_blocks = '0;
				c.wanted_major = '0;
				c.wanted_minor = '0;
				c.wanted_patch = '0;
				c.match_mode = MM_EQUAL;
			end
			2: begin
				c.sector_size = '0;
				c.device_blocks = '1;
				c.wanted_major = '1;
				c.wanted_minor = '1;
				c.wanted_patch = '1;
				c.match_mode = MM_MINOR_LT;
			end
			3: begin
				c.sector_size = 13'd80;
				c.wanted_minor = '0;
				c.match_mode = MM_MINOR_LE;
			end
			4: begin
				c.sector_size = '1;
				c.match_mode = MM_ANY;
			end
			5: begin
				c.sector_size = 13'd4096;
				c.match_mode = MM_EQUAL;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic set_idle(idle_mode_t m);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		case (m)
			IDLE_SEND: send_idle_pct = SEND_IDLE_PCT;
			IDLE_RECV: recv_stall_pct = RECV_STALL_PCT;
			IDLE_BOTH: begin
				send_idle_pct = BOTH_IDLE_PCT;
				recv_stall_pct = BOTH_IDLE_PCT;
			end
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic c, input logic l);
		if (gap_roll()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (gap_roll());
		end
		in_valid <= 1'b1;
		data_byte <= b;
		copy_index <= c;
		byte_last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_byte(b, c, l);
		bytes_sent++;
	endtask

	task automatic write_cfg(input lsv_cfg_t c);
		lsv_reg_t idx;
		logic [47:0] v;
		idx = idx.first();
		forever begin
			case (idx)
				REG_SECTOR_SIZE:   v = 48'(c.sector_size);
				REG_DEVICE_BLOCKS: v = c.device_blocks;
				REG_WANTED_MAJOR:  v = 48'(c.wanted_major);
				REG_WANTED_MINOR:  v = 48'(c.wanted_minor);
				REG_WANTED_PATCH:  v = 48'(c.wanted_patch);
				default:           v = 48'(c.match_mode);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= v;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			board.set_reg(idx, v);
			if (idx == idx.last()) break;
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (board.verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_label(input label_kind_t kind);
		logic [7:0] img[$];
		label_verdict_board scratch;
		int unsigned len, room, nul_at, xl, cut;
		logic [31:0] sum;
		logic copy, cbit, lbit;
		len = board.span();
		room = len - HEADER_BYTES;
		copy = 1'($urandom_range(1));
		for (int i = 0; i < len; i++) img.push_back(8'($urandom_range(255)));
		if (kind == LBL_STUB) begin
			cut = $urandom_range(1, 3);
			while (img.size() > cut) void'(img.pop_back());
		end else if (kind == LBL_NOISE) begin
			cut = $urandom_range(1, len + 3);
			if ($urandom_range(1)) put_le(img, 0, 4, 64'(SECTOR_MAGIC));
			while (img.size() > cut) void'(img.pop_back());
			while (img.size() < cut) img.push_back(8'($urandom_range(255)));
		end else begin
			put_le(img, 0, 4, 64'(SECTOR_MAGIC));
			put_le(img, 8, 8, ($urandom_range(4) != 0) ? {51'd0, board.ss} : {$urandom, $urandom});
			put_le(img, 16, 8, ($urandom_range(4) != 0) ?
				({16'd0, board.blocks} << BLOCK_SHIFT) - {51'd0, board.ss} : {$urandom, $urandom});
			case ($urandom_range(3))
				0: xl = 0;
				1: xl = room;
				default: xl = $urandom_range(room);
			endcase
			if (kind == LBL_TOO_LONG) xl = $urandom_range(1) ? 16'hffff : $urandom_range(room + 1, 65535);
			put_le(img, 24, 2, 64'(xl));
			put_le(img, 28, 4, 64'(near_word(board.want_major)));
			put_le(img, 32, 4, 64'(near_word(board.want_minor)));
			put_le(img, 36, 4, 64'(near_word(board.want_patch)));
			nul_at = $urandom_range(TYPE_TEXT_BYTES - 1);
			for (int i = 0; i < TYPE_TEXT_BYTES; i++) begin
				if (kind == LBL_NO_NUL || i < nul_at) img[TYPE_START+i] = 8'($urandom_range(1, 255));
				else if (i == nul_at) img[TYPE_START+i] = 8'h00;
			end
			scratch = new();
			for (int i = 0; i < len; i++) scratch.take(i, img[i]);
			sum = scratch.crc;
			if (kind == LBL_BAD_CRC) sum ^= 32'h1 << $urandom_range(31);
			put_le(img, 4, 4, 64'(sum));
			if (kind == LBL_BAD_MAGIC) img[$urandom_range(3)] ^= 8'h1 << $urandom_range(7);
			if (kind == LBL_SHORT) begin
				cut = $urandom_range(1, len - 1);
				while (img.size() > cut) void'(img.pop_back());
			end else if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 4)) img.push_back(8'($urandom_range(255)));
			end
		end
		foreach (img[i]) begin
			lbit = (i == img.size() - 1);
			cbit = lbit ? copy : 1'($urandom_range(1));
			send_byte(img[i], cbit, lbit);
		end
	endtask

	initial begin
		lsv_res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.status = lsv_status_t'(status);
				got.valid_res = valid_res;
				got.use_this_copy = use_this_copy;
				got.loc1_wrong = loc1_wrong;
				got.loc2_wrong = loc2_wrong;
				got.version_accepted = version_accepted;
				got.data_length = data_length;
				got.version_major = version_major;
				got.version_minor = version_minor;
				got.version_patch = version_patch;
				board.check_verdict(got);
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		logic [9:0] opening [12];
		int ph;
		board = new();
		// {copy, last, byte}
		opening = '{10'h100, 10'h3ff, 10'h04c, 10'h06e, 10'h058, 10'h06c, 10'h0ff,
			10'h180, 10'h001, 10'h07f, 10'h080, 10'h2aa};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);
		foreach (opening[i]) send_byte(opening[i][7:0], opening[i][9], opening[i][8]);
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				write_cfg(phase_cfg(ph));
			end
			set_idle(idle_mode_t'(ph % 4));
			if (ph == PRESSURE_PHASE) begin
				hold_left = HOLD_CYCLES;
				repeat (40) send_label(LBL_STUB);
			end
			// keep long sectors to stubs so the byte count stays small
			do begin
				send_label((board.span() > 200) ? LBL_STUB : pick_kind());
			end while (bytes_sent < (ph + 1) * PHASE_BYTES);
		end
		drain();
		board.close();
		if (board.failures == 0) begin
			$display("** label_sector_validator_core: PASSED **");
		end else begin
			$display("** label_sector_validator_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** label_sector_validator_core: FAILED **");
		$finish;
	end

endmodule

[files.f]
design/lsv_pkg.sv
design/lsv_front.sv
design/lsv_queue.sv
design/lsv_back.sv
design/label_sector_validator_core.sv
tb/label_sector_validator_core_test.sv
